>>> rtl/fsas_pkg.sv
// ----------------------------------------------------------------------------
// fsas_pkg
// Shared codes, reset values and types for the fire seek and aim sequencer.
// ----------------------------------------------------------------------------
package fsas_pkg;

    // Default widths
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int SERVO_BITS_DEF  = 8;

    // Reset values of the configuration registers
    localparam int FIRE_THR_RST     = 500;
    localparam int LINE_THR_RST     = 500;
    localparam int SERVO_MIN_RST    = 62;
    localparam int SERVO_CENTER_RST = 94;
    localparam int SERVO_MAX_RST    = 125;

    // Threshold registers must hold the reset value even at narrow samples
    localparam int THR_RST_BITS = $clog2(FIRE_THR_RST + 1);

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FIRE_THR     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LINE_THR     = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SERVO_MIN    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SERVO_CENTER = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SERVO_MAX    = 3'd4;

    // Phase codes
    localparam logic [2:0] PH_LINE   = 3'd0;
    localparam logic [2:0] PH_PAN_L  = 3'd1;
    localparam logic [2:0] PH_PAN_R  = 3'd2;
    localparam logic [2:0] PH_TILT_D = 3'd3;
    localparam logic [2:0] PH_TILT_U = 3'd4;
    localparam logic [2:0] PH_PUMP   = 3'd5;

    // Drive bits: bit 1 left, bit 0 right
    localparam logic [1:0] DRIVE_OFF   = 2'd0;
    localparam logic [1:0] DRIVE_RIGHT = 2'd1;
    localparam logic [1:0] DRIVE_LEFT  = 2'd2;
    localparam logic [1:0] DRIVE_BOTH  = 2'd3;

    // Lamp latch: bit 1 up, bit 0 down
    localparam logic [1:0] LAMP_DOWN = 2'd1;
    localparam logic [1:0] LAMP_UP   = 2'd2;

    // Control state that travels between the top level and the step logic
    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] drive;
        logic [1:0] lamps;
    } fsas_ctrl_t;

endpackage

>>> rtl/fsas_step.sv
// ----------------------------------------------------------------------------
// fsas_step
// Next-state and result logic for one sensor tick.
// ----------------------------------------------------------------------------
module fsas_step
    import fsas_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SERVO_BITS  = SERVO_BITS_DEF,
    parameter int THR_BITS    = SAMPLE_BITS
) (
    // configuration
    input  logic [THR_BITS-1:0]    fire_thr,
    input  logic [THR_BITS-1:0]    line_thr,
    input  logic [SERVO_BITS-1:0]  servo_min,
    input  logic [SERVO_BITS-1:0]  servo_center,
    input  logic [SERVO_BITS-1:0]  servo_max,
    // sample
    input  logic [SAMPLE_BITS-1:0] line_left,
    input  logic [SAMPLE_BITS-1:0] line_center,
    input  logic [SAMPLE_BITS-1:0] line_right,
    input  logic [SAMPLE_BITS-1:0] flame_mid,
    input  logic [SAMPLE_BITS-1:0] flame_low,
    input  logic [SAMPLE_BITS-1:0] flame_high,
    // current state
    input  fsas_ctrl_t             ctrl,
    input  logic [SERVO_BITS-1:0]  pan_pos,
    input  logic [SERVO_BITS-1:0]  tilt_pos,
    // next state
    output fsas_ctrl_t             ctrl_next,
    output logic [SERVO_BITS-1:0]  pan_pos_next,
    output logic [SERVO_BITS-1:0]  tilt_pos_next,
    // servo commands for this tick
    output logic [SERVO_BITS-1:0]  pan_cmd,
    output logic [SERVO_BITS-1:0]  tilt_cmd
);

    logic line_c_hit, line_l_hit, line_r_hit;
    logic fire_mid, fire_low, fire_high, mid_below;
    logic [SERVO_BITS:0]   pan_inc, tilt_inc;
    logic [SERVO_BITS-1:0] pan_dec, tilt_dec;

    assign line_c_hit = THR_BITS'(line_center) > line_thr;
    assign line_l_hit = THR_BITS'(line_left)   > line_thr;
    assign line_r_hit = THR_BITS'(line_right)  > line_thr;
    assign fire_mid   = THR_BITS'(flame_mid)   > fire_thr;
    assign fire_low   = THR_BITS'(flame_low)   > fire_thr;
    assign fire_high  = THR_BITS'(flame_high)  > fire_thr;
    assign mid_below  = THR_BITS'(flame_mid)   < fire_thr;

    // one extra bit keeps p + 1 exact; p - 1 is only used when p > min
    assign pan_inc  = {1'b0, pan_pos} + 1'b1;
    assign tilt_inc = {1'b0, tilt_pos} + 1'b1;
    assign pan_dec  = pan_pos - 1'b1;
    assign tilt_dec = tilt_pos - 1'b1;

    always_comb begin
        ctrl_next     = ctrl;
        pan_pos_next  = pan_pos;
        tilt_pos_next = tilt_pos;
        pan_cmd       = pan_pos;
        tilt_cmd      = tilt_pos;

        unique case (ctrl.phase)
            PH_LINE: begin
                if (line_c_hit) begin
                    ctrl_next.drive = DRIVE_BOTH;
                end else if (line_l_hit) begin
                    ctrl_next.drive = DRIVE_RIGHT;
                end else if (line_r_hit) begin
                    ctrl_next.drive = DRIVE_LEFT;
                end else begin
                    ctrl_next.drive = DRIVE_OFF;
                    ctrl_next.phase = PH_PAN_L;
                end
            end
            PH_PAN_L, PH_PAN_R: begin
                if ((ctrl.phase == PH_PAN_L) ? (pan_pos < servo_max)
                                             : (pan_pos > servo_min)) begin
                    // flame priority: middle, bottom, top
                    if (fire_mid) begin
                        ctrl_next.phase = PH_PUMP;
                    end else if (fire_low) begin
                        ctrl_next.lamps = ctrl.lamps | LAMP_DOWN;
                        tilt_pos_next   = servo_center;
                        ctrl_next.phase = PH_TILT_D;
                    end else if (fire_high) begin
                        ctrl_next.lamps = ctrl.lamps | LAMP_UP;
                        tilt_pos_next   = servo_center;
                        ctrl_next.phase = PH_TILT_U;
                    end else if (ctrl.phase == PH_PAN_L) begin
                        if (pan_inc < {1'b0, servo_max}) begin
                            pan_pos_next = pan_inc[SERVO_BITS-1:0];
                        end else begin
                            ctrl_next.phase = PH_PAN_R;
                        end
                    end else begin
                        if (pan_dec > servo_min) begin
                            pan_pos_next = pan_dec;
                        end else begin
                            ctrl_next.phase = PH_PAN_L;
                        end
                    end
                end else begin
                    // at or past the limit: turn around only
                    ctrl_next.phase = (ctrl.phase == PH_PAN_L) ? PH_PAN_R : PH_PAN_L;
                end
            end
            PH_TILT_D: begin
                if (tilt_pos > servo_min) begin
                    if (fire_mid) begin
                        ctrl_next.phase = PH_PUMP;
                    end else if (tilt_dec > servo_min) begin
                        tilt_pos_next = tilt_dec;
                    end else begin
                        tilt_pos_next = servo_center;
                    end
                end else begin
                    tilt_pos_next = servo_center;
                end
            end
            PH_TILT_U: begin
                if (tilt_pos < servo_max) begin
                    if (fire_mid) begin
                        ctrl_next.phase = PH_PUMP;
                    end else if (tilt_inc < {1'b0, servo_max}) begin
                        tilt_pos_next = tilt_inc[SERVO_BITS-1:0];
                    end else begin
                        tilt_pos_next = servo_center;
                    end
                end else begin
                    tilt_pos_next = servo_center;
                end
            end
            PH_PUMP: begin
                if (mid_below) begin
                    ctrl_next.phase = PH_LINE;
                    ctrl_next.lamps = '0;
                    tilt_pos_next   = servo_center;
                end
            end
            default: begin
                // unused codes fall back to line follow
                ctrl_next.phase = PH_LINE;
                ctrl_next.lamps = '0;
                tilt_pos_next   = servo_center;
            end
        endcase

        // commands show the visited position while a sweep is inside its range
        if ((ctrl.phase == PH_PAN_L && pan_pos < servo_max) ||
            (ctrl.phase == PH_PAN_R && pan_pos > servo_min)) begin
            pan_cmd = pan_pos;
        end
        if ((ctrl.phase == PH_TILT_D && tilt_pos > servo_min) ||
            (ctrl.phase == PH_TILT_U && tilt_pos < servo_max)) begin
            tilt_cmd = tilt_pos;
        end
    end

endmodule

>>> rtl/fire_seek_and_aim_sequencer.sv
// ----------------------------------------------------------------------------
// fire_seek_and_aim_sequencer
// Line follow, pan and tilt flame search and pump control, one result per
// sensor tick.
// ----------------------------------------------------------------------------
//  channel | ports                         | transfer when
//  --------+-------------------------------+---------------------------
//  input   | s_valid/s_ready, s_*_level    | s_valid & s_ready
//  result  | m_valid/m_ready, m_* fields   | m_valid & m_ready
//  config  | cfg_wen, cfg_addr, cfg_wdata  | cfg_wen (no wait)
//
//  Path: an input transfer goes to the sample register, then to the result
//  register; one tick per cycle sustained while results are taken.
//  The tick logic is a handful of compares plus increments and decrements on
//  the servo positions between the sample register and the result register.
//  Reset (aresetn low, synchronous) empties both stages, loads the register
//  reset values and puts the sequencer in line follow, servos centered.
//  A stalled result holds in its register; the sample stage still moves in
//  when the result register frees in the same cycle, so no bubble appears.
// ----------------------------------------------------------------------------
module fire_seek_and_aim_sequencer
    import fsas_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SERVO_BITS  = SERVO_BITS_DEF,
    localparam int CFG_BITS   = (SAMPLE_BITS > SERVO_BITS) ? SAMPLE_BITS : SERVO_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    // configuration write port
    input  logic                     cfg_wen,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_BITS-1:0]      cfg_wdata,

    // sample input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SAMPLE_BITS-1:0]   s_line_left_level,
    input  logic [SAMPLE_BITS-1:0]   s_line_center_level,
    input  logic [SAMPLE_BITS-1:0]   s_line_right_level,
    input  logic [SAMPLE_BITS-1:0]   s_flame_mid_level,
    input  logic [SAMPLE_BITS-1:0]   s_flame_low_level,
    input  logic [SAMPLE_BITS-1:0]   s_flame_high_level,

    // result output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_drive_left,
    output logic                     m_drive_right,
    output logic [SERVO_BITS-1:0]    m_pan_width,
    output logic [SERVO_BITS-1:0]    m_tilt_width,
    output logic                     m_search_lamp,
    output logic                     m_aim_up_lamp,
    output logic                     m_aim_down_lamp,
    output logic                     m_pump_on,
    output logic [2:0]               m_phase
);

    // Thresholds keep at least enough bits for their reset value, so a
    // narrow sample width never truncates the default.
    localparam int THR_BITS = (SAMPLE_BITS > THR_RST_BITS) ? SAMPLE_BITS : THR_RST_BITS;

    // ---------------- configuration registers ----------------
    logic [THR_BITS-1:0]   fire_thr_reg, line_thr_reg;
    logic [SERVO_BITS-1:0] servo_min_reg, servo_center_reg, servo_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fire_thr_reg     <= THR_BITS'(FIRE_THR_RST);
            line_thr_reg     <= THR_BITS'(LINE_THR_RST);
            servo_min_reg    <= SERVO_BITS'(SERVO_MIN_RST);
            servo_center_reg <= SERVO_BITS'(SERVO_CENTER_RST);
            servo_max_reg    <= SERVO_BITS'(SERVO_MAX_RST);
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_FIRE_THR:     fire_thr_reg     <= THR_BITS'(cfg_wdata[SAMPLE_BITS-1:0]);
                REG_LINE_THR:     line_thr_reg     <= THR_BITS'(cfg_wdata[SAMPLE_BITS-1:0]);
                REG_SERVO_MIN:    servo_min_reg    <= cfg_wdata[SERVO_BITS-1:0];
                REG_SERVO_CENTER: servo_center_reg <= cfg_wdata[SERVO_BITS-1:0];
                REG_SERVO_MAX:    servo_max_reg    <= cfg_wdata[SERVO_BITS-1:0];
                default: ;  // writes past the list are dropped
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_free;   // result register can take a value this cycle
    logic advance;    // sample stage moves into the result register

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // ---------------- sample register ----------------
    logic [SAMPLE_BITS-1:0] ll_reg, lc_reg, lr_reg, fm_reg, fl_reg, fh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ll_reg <= s_line_left_level;
            lc_reg <= s_line_center_level;
            lr_reg <= s_line_right_level;
            fm_reg <= s_flame_mid_level;
            fl_reg <= s_flame_low_level;
            fh_reg <= s_flame_high_level;
        end
    end

    // ---------------- sequencer state ----------------
    fsas_ctrl_t            ctrl_reg, ctrl_next;
    logic [SERVO_BITS-1:0] pan_pos_reg, pan_pos_next;
    logic [SERVO_BITS-1:0] tilt_pos_reg, tilt_pos_next;
    logic [SERVO_BITS-1:0] pan_cmd, tilt_cmd;

    fsas_step #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SERVO_BITS  (SERVO_BITS),
        .THR_BITS    (THR_BITS)
    ) u_step (
        .fire_thr      (fire_thr_reg),
        .line_thr      (line_thr_reg),
        .servo_min     (servo_min_reg),
        .servo_center  (servo_center_reg),
        .servo_max     (servo_max_reg),
        .line_left     (ll_reg),
        .line_center   (lc_reg),
        .line_right    (lr_reg),
        .flame_mid     (fm_reg),
        .flame_low     (fl_reg),
        .flame_high    (fh_reg),
        .ctrl          (ctrl_reg),
        .pan_pos       (pan_pos_reg),
        .tilt_pos      (tilt_pos_reg),
        .ctrl_next     (ctrl_next),
        .pan_pos_next  (pan_pos_next),
        .tilt_pos_next (tilt_pos_next),
        .pan_cmd       (pan_cmd),
        .tilt_cmd      (tilt_cmd)
    );

    // State commits only when a tick moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg     <= '{phase: PH_LINE, drive: DRIVE_OFF, lamps: 2'b00};
            pan_pos_reg  <= SERVO_BITS'(SERVO_CENTER_RST);
            tilt_pos_reg <= SERVO_BITS'(SERVO_CENTER_RST);
        end else if (advance) begin
            ctrl_reg     <= ctrl_next;
            pan_pos_reg  <= pan_pos_next;
            tilt_pos_reg <= tilt_pos_next;
        end
    end

    // ---------------- result register ----------------
    fsas_ctrl_t            res_ctrl_reg;
    logic [SERVO_BITS-1:0] res_pan_reg, res_tilt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_ctrl_reg <= ctrl_next;
            res_pan_reg  <= pan_cmd;
            res_tilt_reg <= tilt_cmd;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_drive_left    = res_ctrl_reg.drive[1];
    assign m_drive_right   = res_ctrl_reg.drive[0];
    assign m_pan_width     = res_pan_reg;
    assign m_tilt_width    = res_tilt_reg;
    assign m_search_lamp   = (res_ctrl_reg.phase == PH_PAN_L) ||
                             (res_ctrl_reg.phase == PH_PAN_R);
    assign m_aim_up_lamp   = res_ctrl_reg.lamps[1];
    assign m_aim_down_lamp = res_ctrl_reg.lamps[0];
    assign m_pump_on       = (res_ctrl_reg.phase == PH_PUMP);
    assign m_phase         = res_ctrl_reg.phase;

endmodule

>>> rtl/fsas_checker.sv
// ----------------------------------------------------------------------------
// fsas_checker
// Port-level checks for the fire seek and aim sequencer, bound to the top.
// ----------------------------------------------------------------------------
module fsas_checker
    import fsas_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_search_lamp,
    input logic       m_aim_up_lamp,
    input logic       m_aim_down_lamp,
    input logic       m_pump_on,
    input logic [2:0] m_phase
);

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_phase) && $stable(m_pump_on))
        else $error("stalled result changed");

    // pump indicator agrees with the phase
    a_pump_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pump_on == (m_phase == PH_PUMP)))
        else $error("pump_on disagrees with phase");

    // search lamp agrees with the pan phases
    a_search_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_search_lamp == ((m_phase == PH_PAN_L) || (m_phase == PH_PAN_R))))
        else $error("search lamp disagrees with phase");

    // aim lamps are cleared in line follow and never both lit
    a_lamps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_aim_up_lamp && m_aim_down_lamp) &&
                    !((m_phase == PH_LINE) && (m_aim_up_lamp || m_aim_down_lamp)))
        else $error("aim lamps in an impossible combination");

endmodule

bind fire_seek_and_aim_sequencer fsas_checker u_fsas_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_search_lamp   (m_search_lamp),
    .m_aim_up_lamp   (m_aim_up_lamp),
    .m_aim_down_lamp (m_aim_down_lamp),
    .m_pump_on       (m_pump_on),
    .m_phase         (m_phase)
);
